FILE: rtl/core/leb_pkg.sv
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared types and constants for the line edit buffer controller and datapath.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ERASE_CHAR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KILL_CHAR  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_CHAR   = 2'd2;

   // Register values after reset.
   localparam logic [BYTE_W-1:0] ERASE_CHAR_RESET = 8'd35;  // '#'
   localparam logic [BYTE_W-1:0] KILL_CHAR_RESET  = 8'd64;  // '@'
   localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'd10;  // newline
   localparam logic [BYTE_W-1:0] NUL_CHAR         = 8'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;      // a request is accepted this cycle
      logic rd_en;     // read the line store at the current index
      logic advance;   // step the read index to the next character
   } leb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_release;  // the offered byte ends the line
      logic line_empty;  // no characters are stored
      logic at_last;     // the result on display closes the line
   } leb_status_type;

endpackage

FILE: rtl/core/leb_ram.sv
// ----------------------------------------------------------------------------
// Line edit buffer RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/leb_ctrl.sv
// ----------------------------------------------------------------------------
// Line edit buffer controller
// Sequences request intake and the character-by-character release of a line.
// ----------------------------------------------------------------------------
module leb_ctrl
   import leb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output leb_cmd_type    cmd,
   input  leb_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.take    = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.is_release) begin
                  state_in = status.line_empty ? ST_SHOW : ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/leb_dp.sv
// ----------------------------------------------------------------------------
// Line edit buffer datapath
// Control registers, fill count, line store and the result register.
// ----------------------------------------------------------------------------
module leb_dp
   import leb_pkg::*;
#(
   parameter int LINE_DEPTH = 64,
   localparam int AW = $clog2(LINE_DEPTH),
   localparam int CW = $clog2(LINE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic [BYTE_W-1:0]      req_in_byte,
   input  leb_cmd_type            cmd,
   output leb_status_type         status,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_has_char,
   output logic                   rsp_line_overflow,
   output logic                   rsp_last
);

   logic [BYTE_W-1:0] erase_char_ff, erase_char_in;
   logic [BYTE_W-1:0] kill_char_ff, kill_char_in;
   logic [BYTE_W-1:0] end_char_ff, end_char_in;
   logic [CW-1:0]     fill_count_ff, fill_count_in;
   logic              overflow_ff, overflow_in;
   logic [CW-1:0]     line_len_ff, line_len_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              has_char_ff, has_char_in;
   logic              last_ff, last_in;
   logic              line_ovf_ff, line_ovf_in;
   logic              is_release, is_erase, is_kill, is_full;
   logic              wr_en;
   logic [BYTE_W-1:0] rd_data;

   assign is_release = (req_in_byte == NUL_CHAR) || (req_in_byte == end_char_ff);
   assign is_erase   = req_in_byte == erase_char_ff;
   assign is_kill    = req_in_byte == kill_char_ff;
   assign is_full    = fill_count_ff == CW'(LINE_DEPTH);
   assign wr_en      = cmd.take && !is_release && !is_erase && !is_kill && !is_full;

   always_comb begin
      erase_char_in = erase_char_ff;
      kill_char_in  = kill_char_ff;
      end_char_in   = end_char_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ERASE_CHAR: erase_char_in = csr_wdata;
            CSR_KILL_CHAR:  kill_char_in  = csr_wdata;
            CSR_END_CHAR:   end_char_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      line_len_in   = line_len_ff;
      rd_idx_in     = rd_idx_ff;
      has_char_in   = has_char_ff;
      last_in       = last_ff;
      line_ovf_in   = line_ovf_ff;
      if (cmd.take) begin
         if (is_release) begin
            line_len_in   = fill_count_ff;
            line_ovf_in   = overflow_ff;
            rd_idx_in     = '0;
            fill_count_in = '0;
            overflow_in   = 1'b0;
            // An empty line shows one result without a character.
            has_char_in   = 1'b0;
            last_in       = 1'b1;
         end else if (is_erase) begin
            if (fill_count_ff != '0) begin
               fill_count_in = fill_count_ff - CW'(1);
            end
         end else if (is_kill) begin
            fill_count_in = '0;
            overflow_in   = 1'b0;
         end else if (is_full) begin
            overflow_in = 1'b1;
         end else begin
            fill_count_in = fill_count_ff + CW'(1);
         end
      end
      if (cmd.rd_en) begin
         has_char_in = 1'b1;
         last_in     = (CW'(rd_idx_ff) + CW'(1)) == line_len_ff;
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_char_ff <= ERASE_CHAR_RESET;
         kill_char_ff  <= KILL_CHAR_RESET;
         end_char_ff   <= END_CHAR_RESET;
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         erase_char_ff <= erase_char_in;
         kill_char_ff  <= kill_char_in;
         end_char_ff   <= end_char_in;
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      line_len_ff <= line_len_in;
      rd_idx_ff   <= rd_idx_in;
      has_char_ff <= has_char_in;
      last_ff     <= last_in;
      line_ovf_ff <= line_ovf_in;
   end

   leb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_count_ff[AW-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign status.is_release = is_release;
   assign status.line_empty = fill_count_ff == '0;
   assign status.at_last    = last_ff;

   assign rsp_out_byte      = has_char_ff ? rd_data : NUL_CHAR;
   assign rsp_has_char      = has_char_ff;
   assign rsp_line_overflow = line_ovf_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/core/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// Line edit buffer
// Collects text bytes into a line with erase and kill editing, releases lines.
// ----------------------------------------------------------------------------
// Each request carries one text byte. A byte that is stored, erased, killed or
// dropped is handled on acceptance, and the block is ready again in the next
// cycle. The end byte or a NUL byte releases the stored line, oldest character
// first, as a run of responses with rsp_last on the final one; an empty line
// gives one response with rsp_has_char low. For each character the block
// reads the line store RAM through its registered read port and then presents
// the response, which holds until rsp_ready. No request is accepted during a
// release. Once LINE_DEPTH characters are stored, further characters are
// dropped and every response of that line shows rsp_line_overflow. The erase,
// kill and end bytes are written through the csr_ port (index 0, 1 and 2);
// other indexes are ignored. The user must write them only while the block
// is idle; the block itself does not enforce this. The line store needs no
// clearing after reset, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int LINE_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_has_char,
   output logic                   rsp_line_overflow,
   output logic                   rsp_last
);

   leb_cmd_type    cmd;
   leb_status_type status;

   // The controller owns the handshakes; the datapath owns all storage.
   leb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   leb_dp #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_in_byte       (req_in_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_char      (rsp_has_char),
      .rsp_line_overflow (rsp_line_overflow),
      .rsp_last          (rsp_last)
   );

endmodule
